FILE: sv/pgp_sfe_pkg.sv
`timescale 1ns / 1ps
package pgp_sfe_pkg;
   localparam logic [4:0] PH_CTB      = 5'd0;
   localparam logic [4:0] PH_NEWLEN   = 5'd1;
   localparam logic [4:0] PH_NEWLEN2  = 5'd2;
   localparam logic [4:0] PH_HDRLEN   = 5'd3;
   localparam logic [4:0] PH_VER      = 5'd4;
   localparam logic [4:0] PH_V3LEN    = 5'd5;
   localparam logic [4:0] PH_V3TYPE   = 5'd6;
   localparam logic [4:0] PH_V3TIME   = 5'd7;
   localparam logic [4:0] PH_V3KEY    = 5'd8;
   localparam logic [4:0] PH_V4HDR    = 5'd9;
   localparam logic [4:0] PH_AREALEN  = 5'd10;
   localparam logic [4:0] PH_SUBLEN   = 5'd11;
   localparam logic [4:0] PH_SUBLEN2  = 5'd12;
   localparam logic [4:0] PH_SUBLEN4  = 5'd13;
   localparam logic [4:0] PH_SUBTYPE  = 5'd14;
   localparam logic [4:0] PH_SUBDATA  = 5'd15;
   localparam logic [4:0] PH_AREASKIP = 5'd16;
   localparam logic [4:0] PH_REST     = 5'd17;

   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_BAD_CTB   = 4'd1;
   localparam logic [3:0] ST_PARTIAL   = 4'd2;
   localparam logic [3:0] ST_NOT_SIG   = 4'd3;
   localparam logic [3:0] ST_SHORT     = 4'd4;
   localparam logic [3:0] ST_VERSION   = 4'd5;
   localparam logic [3:0] ST_V3_LEN    = 4'd6;
   localparam logic [3:0] ST_V3_TYPE   = 4'd7;
   localparam logic [3:0] ST_ZERO_SUB  = 4'd8;
   localparam logic [3:0] ST_MISSIZED  = 4'd9;
   localparam logic [3:0] ST_AREA_OVR  = 4'd10;
   localparam logic [3:0] ST_TIME_UNH  = 4'd11;
   localparam logic [3:0] ST_NO_TIME   = 4'd12;
   localparam logic [3:0] ST_NO_KEY    = 4'd13;
   localparam logic [3:0] ST_TRUNC     = 4'd14;
   localparam logic [3:0] ST_PKT_OVR   = 4'd15;

   localparam logic [7:0] SUB_TIME = 8'd2;
   localparam logic [7:0] SUB_KEY  = 8'd16;
   localparam logic [7:0] SIG_TAG  = 8'd2;
   localparam logic [31:0] MIN_BODY = 32'd19;

   // parser state carried from one byte to the next
   typedef struct packed {
      logic [4:0]  phase;
      logic [2:0]  old_left;
      logic [31:0] pkt_rem;
      logic [15:0] area_rem;
      logic [31:0] sub_rem;
      logic [7:0]  kind;
      logic [63:0] shift;
      logic [3:0]  fld_left;
      logic [31:0] time_val;
      logic [63:0] key_val;
      logic [2:0]  found;
      logic [32:0] count;
      logic [7:0]  version;
      logic        area_short;
   } parse_state_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [7:0]  version;
      logic [31:0] time_val;
      logic [63:0] key_val;
      logic [32:0] count;
   } result_type;
endpackage

FILE: sv/pgp_sfe_step.sv
`timescale 1ns / 1ps
module pgp_sfe_step (
   input  pgp_sfe_pkg::parse_state_type cur,
   input  logic [7:0]                   data_byte,
   input  logic                         stream_end,
   output pgp_sfe_pkg::parse_state_type nxt,
   output logic                         fire,
   output pgp_sfe_pkg::result_type     res
);
   import pgp_sfe_pkg::*;

   parse_state_type s;
   parse_state_type zero_state;
   logic        err;
   logic [3:0]  st;
   logic [32:0] sub_total;
   logic [31:0] sub_len;
   logic [2:0]  hdr_bytes;
   logic        do_sub_len;
   logic        do_sub_done;
   logic        do_next_area;
   logic        do_area_done;
   logic        do_header_done;
   logic [31:0] tmp_rem;
   logic [2:0]  tmp_old;
   logic [3:0]  tmp_fld;

   always_comb begin
      zero_state = '0;
      s = cur;
      err = 1'b0;
      st = ST_OK;
      sub_len = '0;
      hdr_bytes = '0;
      sub_total = '0;
      do_sub_len = 1'b0;
      do_sub_done = 1'b0;
      do_next_area = 1'b0;
      do_area_done = 1'b0;
      do_header_done = 1'b0;
      tmp_rem = '0;
      tmp_old = '0;
      tmp_fld = '0;
      s.count = cur.count + 33'd1;
      if (cur.phase >= PH_VER && cur.pkt_rem != 32'd0) begin
         s.pkt_rem = cur.pkt_rem - 32'd1;
      end
      case (cur.phase)
         PH_CTB: begin
            if (!data_byte[7]) begin
               err = 1'b1; st = ST_BAD_CTB;
            end else if (data_byte[6]) begin
               s.kind = {2'b00, data_byte[5:0]};
               s.phase = PH_NEWLEN;
            end else begin
               s.kind = {4'd0, data_byte[5:2]};
               if (data_byte[1:0] == 2'd3) begin
                  err = 1'b1; st = ST_PARTIAL;
               end else begin
                  s.old_left = 3'd1 << data_byte[1:0];
                  s.pkt_rem = '0;
                  s.phase = PH_HDRLEN;
               end
            end
         end
         PH_NEWLEN: begin
            if (data_byte < 8'd192) begin
               s.pkt_rem = {24'd0, data_byte};
               do_header_done = 1'b1;
            end else if (data_byte < 8'd224) begin
               s.pkt_rem = {16'd0, data_byte - 8'd192, 8'd0};
               s.phase = PH_NEWLEN2;
            end else if (data_byte == 8'd255) begin
               s.old_left = 3'd4;
               s.pkt_rem = '0;
               s.phase = PH_HDRLEN;
            end else begin
               err = 1'b1; st = ST_PARTIAL;
            end
         end
         PH_NEWLEN2: begin
            s.pkt_rem = cur.pkt_rem + {24'd0, data_byte} + 32'd192;
            do_header_done = 1'b1;
         end
         PH_HDRLEN: begin
            s.pkt_rem = {cur.pkt_rem[23:0], data_byte};
            tmp_old = (cur.old_left != 3'd0) ? cur.old_left - 3'd1 : 3'd0;
            s.old_left = tmp_old;
            if (tmp_old == 3'd0) do_header_done = 1'b1;
         end
         PH_VER: begin
            s.version = data_byte;
            if (data_byte == 8'd3) begin
               s.phase = PH_V3LEN;
            end else if (data_byte == 8'd4) begin
               s.fld_left = 4'd3;
               s.phase = PH_V4HDR;
            end else begin
               err = 1'b1; st = ST_VERSION;
            end
         end
         PH_V3LEN: begin
            if (data_byte != 8'd5) begin
               err = 1'b1; st = ST_V3_LEN;
            end else begin
               s.phase = PH_V3TYPE;
            end
         end
         PH_V3TYPE: begin
            if (data_byte[7:4] != 4'd0) begin
               err = 1'b1; st = ST_V3_TYPE;
            end else begin
               s.shift = '0;
               s.fld_left = 4'd4;
               s.phase = PH_V3TIME;
            end
         end
         PH_V3TIME: begin
            s.shift = {cur.shift[55:0], data_byte};
            tmp_fld = cur.fld_left - 4'd1;
            s.fld_left = tmp_fld;
            if (tmp_fld == 4'd0) begin
               s.time_val = s.shift[31:0];
               s.shift = '0;
               s.fld_left = 4'd8;
               s.phase = PH_V3KEY;
            end
         end
         PH_V3KEY: begin
            s.shift = {cur.shift[55:0], data_byte};
            tmp_fld = cur.fld_left - 4'd1;
            s.fld_left = tmp_fld;
            if (tmp_fld == 4'd0) begin
               s.key_val = s.shift;
               s.phase = PH_REST;
            end
         end
         PH_V4HDR: begin
            tmp_fld = cur.fld_left - 4'd1;
            s.fld_left = tmp_fld;
            if (tmp_fld == 4'd0) begin
               s.fld_left = 4'd2;
               s.area_rem = '0;
               s.phase = PH_AREALEN;
            end
         end
         PH_AREALEN: begin
            s.area_rem = {cur.area_rem[7:0], data_byte};
            tmp_fld = cur.fld_left - 4'd1;
            s.fld_left = tmp_fld;
            if (tmp_fld == 4'd0) do_next_area = 1'b1;
         end
         PH_SUBLEN: begin
            if (data_byte < 8'd192) begin
               sub_len = {24'd0, data_byte};
               hdr_bytes = 3'd1;
               do_sub_len = 1'b1;
            end else if (data_byte < 8'd255) begin
               s.sub_rem = {16'd0, data_byte - 8'd192, 8'd0};
               s.phase = PH_SUBLEN2;
            end else begin
               s.sub_rem = '0;
               s.old_left = 3'd4;
               s.phase = PH_SUBLEN4;
            end
         end
         PH_SUBLEN2: begin
            sub_len = cur.sub_rem + {24'd0, data_byte} + 32'd192;
            hdr_bytes = 3'd2;
            do_sub_len = 1'b1;
         end
         PH_SUBLEN4: begin
            s.sub_rem = {cur.sub_rem[23:0], data_byte};
            tmp_old = (cur.old_left != 3'd0) ? cur.old_left - 3'd1 : 3'd0;
            s.old_left = tmp_old;
            if (tmp_old == 3'd0) begin
               sub_len = s.sub_rem;
               hdr_bytes = 3'd5;
               do_sub_len = 1'b1;
            end
         end
         PH_SUBTYPE: begin
            s.kind = data_byte;
            tmp_rem = cur.sub_rem - 32'd1;
            s.sub_rem = tmp_rem;
            if ((data_byte == SUB_TIME && tmp_rem != 32'd4) ||
                (data_byte == SUB_KEY && tmp_rem != 32'd8)) begin
               err = 1'b1; st = ST_MISSIZED;
            end else begin
               s.shift = '0;
               if (tmp_rem == 32'd0) do_sub_done = 1'b1;
               else s.phase = PH_SUBDATA;
            end
         end
         PH_SUBDATA: begin
            s.shift = {cur.shift[55:0], data_byte};
            tmp_rem = cur.sub_rem - 32'd1;
            s.sub_rem = tmp_rem;
            if (tmp_rem == 32'd0) do_sub_done = 1'b1;
         end
         PH_AREASKIP: begin
            if (cur.area_rem != 16'd0) s.area_rem = cur.area_rem - 16'd1;
            if (s.area_rem == 16'd0) do_area_done = 1'b1;
         end
         default: begin
         end
      endcase

      if (do_header_done) begin
         if (s.kind != SIG_TAG) begin
            err = 1'b1; st = ST_NOT_SIG;
         end else if (s.pkt_rem < MIN_BODY) begin
            err = 1'b1; st = ST_SHORT;
         end else begin
            s.phase = PH_VER;
         end
      end

      if (do_sub_len) begin
         if (sub_len == 32'd0) begin
            err = 1'b1; st = ST_ZERO_SUB;
         end else begin
            sub_total = {1'b0, sub_len} + {30'd0, hdr_bytes};
            if (sub_total > {17'd0, s.area_rem}) begin
               s.area_short = 1'b1;
               s.area_rem = '0;
            end else begin
               s.area_rem = s.area_rem - sub_total[15:0];
            end
            s.sub_rem = sub_len;
            s.phase = PH_SUBTYPE;
         end
      end

      // subpacket end: unless an error ends the packet, commit field, then fall into next-in-area
      if (do_sub_done) begin
         if (s.area_short) begin
            err = 1'b1; st = ST_AREA_OVR;
         end else if (s.kind == SUB_TIME) begin
            if (s.found[2]) begin
               err = 1'b1; st = ST_TIME_UNH;
            end else begin
               s.time_val = s.shift[31:0];
               s.found[0] = 1'b1;
               do_next_area = 1'b1;
            end
         end else begin
            if (s.kind == SUB_KEY) begin
               s.key_val = s.shift;
               s.found[1] = 1'b1;
            end
            do_next_area = 1'b1;
         end
      end

      if (do_next_area) begin
         if (s.area_rem == 16'd0) do_area_done = 1'b1;
         else s.phase = (s.found[1:0] == 2'b11) ? PH_AREASKIP : PH_SUBLEN;
      end

      if (do_area_done) begin
         if (!s.found[2]) begin
            s.found[2] = 1'b1;
            s.fld_left = 4'd2;
            s.area_rem = '0;
            s.phase = PH_AREALEN;
         end else if (!s.found[0]) begin
            err = 1'b1; st = ST_NO_TIME;
         end else if (!s.found[1]) begin
            err = 1'b1; st = ST_NO_KEY;
         end else begin
            s.phase = PH_REST;
         end
      end

      if (!err && s.phase >= PH_VER && s.pkt_rem == 32'd0) begin
         err = 1'b1;
         st = (s.phase == PH_REST) ? ST_OK : ST_PKT_OVR;
      end

      if (stream_end) begin
         fire = 1'b1;
         res = '{status: ST_TRUNC, version: cur.version, time_val: cur.time_val,
                 key_val: cur.key_val, count: cur.count};
         nxt = zero_state;
      end else if (err) begin
         fire = 1'b1;
         res = '{status: st, version: s.version, time_val: s.time_val,
                 key_val: s.key_val, count: s.count};
         nxt = zero_state;
      end else begin
         fire = 1'b0;
         res = '{status: st, version: s.version, time_val: s.time_val,
                 key_val: s.key_val, count: s.count};
         nxt = s;
      end
   end
endmodule

FILE: sv/pgp_signature_field_extractor_core.sv
`timescale 1ns / 1ps
// A result is registered: it leaves the output register in the cycle after the item that causes it is accepted.
// Throughput: one item per cycle while req_stall is low; the parse state updates in one pass of the step logic.
// The output register refills in the same cycle it is taken, so stall only holds the input.
// Reset (synchronous, active high) returns the parser to "expect header first byte"
// and empties the output register.
module pgp_signature_field_extractor_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_stream_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic [7:0]  rsp_sig_version,
   output logic [31:0] rsp_creation_time,
   output logic [63:0] rsp_key_id,
   output logic [32:0] rsp_byte_count
);
   import pgp_sfe_pkg::*;

   parse_state_type state_ff, state_in, step_nxt;
   result_type      res_ff, res_in, step_res;
   logic            valid_ff, valid_in;
   logic            step_fire;
   logic            accept;

   pgp_sfe_step u_step (
      .cur        (state_ff),
      .data_byte  (req_data_byte),
      .stream_end (req_stream_end),
      .nxt        (step_nxt),
      .fire       (step_fire),
      .res        (step_res)
   );

   // input waits only while the output holds an untaken item
   assign req_stall = valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      state_in = state_ff;
      res_in   = res_ff;
      valid_in = valid_ff & rsp_stall;
      if (accept) begin
         state_in = step_nxt;
         if (step_fire) begin
            res_in   = step_res;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = res_ff.status;
   assign rsp_sig_version   = res_ff.version;
   assign rsp_creation_time = res_ff.time_val;
   assign rsp_key_id        = res_ff.key_val;
   assign rsp_byte_count    = res_ff.count;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)))
      else $error("result overwritten while stalled");
   a_stream_end_fires: assert property (@(posedge clock) disable iff (reset)
      (accept && req_stream_end) |=> (rsp_valid && rsp_status == ST_TRUNC))
      else $error("stream end gave no truncation result");
   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      (accept && step_fire) |=> (state_ff.phase == PH_CTB && state_ff.count == 33'd0))
      else $error("state not cleared after result");
endmodule

FILE: tb/sv/tb_pgp_signature_field_extractor_core.sv
`timescale 1ns / 1ps
module tb_pgp_signature_field_extractor_core;
   import pgp_sfe_pkg::*;

   localparam int NO_RESULT = -1;
   // stimulus entry kinds
   localparam int ENT_BYTE  = 0;
   localparam int ENT_HOLD  = 1;   // ask the receiver for a long hold-off
   localparam int ENT_DRAIN = 2;   // sender waits until every result is in

   typedef struct {
      int         kind;
      logic [7:0] data;
      logic       eos;
   } stim_entry_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_stream_end;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [3:0]  rsp_status;
   logic [7:0]  rsp_sig_version;
   logic [31:0] rsp_creation_time;
   logic [63:0] rsp_key_id;
   logic [32:0] rsp_byte_count;

   pgp_signature_field_extractor_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_stream_end    (req_stream_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_sig_version   (rsp_sig_version),
      .rsp_creation_time (rsp_creation_time),
      .rsp_key_id        (rsp_key_id),
      .rsp_byte_count    (rsp_byte_count)
   );

   stim_entry_type stim_q[$];
   result_type     sig_result_q[$];
   int          err_count;
   int          cyc;
   int          hold_ticket;
   int          hold_seen;
   int          hold_left;
   int          byte_total;
   int          hold_ticket_marked = 0;
   int          drain_marked = 0;

   // ---------------------------------------------------------------
   // Parser mirror: one copy of the packet walk state
   // ---------------------------------------------------------------
   logic [4:0]  m_phase;
   logic [2:0]  m_len_left;
   logic [31:0] m_pkt_rem;
   logic [15:0] m_area_rem;
   logic [31:0] m_sub_rem;
   logic [7:0]  m_kind;
   logic [63:0] m_shift;
   logic [3:0]  m_fld_left;
   logic [31:0] m_time;
   logic [63:0] m_key;
   logic [2:0]  m_found;      // bit0 time, bit1 key, bit2 unhashed area
   logic [32:0] m_count;
   logic [7:0]  m_version;
   logic        m_area_short;

   function automatic void mirror_clear();
      m_phase = PH_CTB;  m_len_left = '0; m_pkt_rem = '0; m_area_rem = '0;
      m_sub_rem = '0;    m_kind = '0;     m_shift = '0;   m_fld_left = '0;
      m_time = '0;       m_key = '0;      m_found = '0;   m_count = '0;
      m_version = '0;    m_area_short = 1'b0;
   endfunction

   function automatic int header_check();
      if (m_kind != SIG_TAG) return ST_NOT_SIG;
      if (m_pkt_rem < MIN_BODY) return ST_SHORT;
      m_phase = PH_VER;
      return NO_RESULT;
   endfunction

   function automatic int area_finish();
      if (!m_found[2]) begin
         m_found[2] = 1'b1;
         m_fld_left = 4'd2;
         m_area_rem = '0;
         m_phase = PH_AREALEN;
         return NO_RESULT;
      end
      if (!m_found[0]) return ST_NO_TIME;
      if (!m_found[1]) return ST_NO_KEY;
      m_phase = PH_REST;
      return NO_RESULT;
   endfunction

   function automatic int area_next();
      if (m_area_rem == 0) return area_finish();
      m_phase = (m_found[1:0] == 2'b11) ? PH_AREASKIP : PH_SUBLEN;
      return NO_RESULT;
   endfunction

   function automatic int sublen_set(logic [31:0] len, int hdr);
      logic [63:0] total;
      if (len == 0) return ST_ZERO_SUB;
      total = 64'(len) + 64'(hdr);
      if (total > 64'(m_area_rem)) begin
         m_area_short = 1'b1;
         m_area_rem = '0;
      end else begin
         m_area_rem = m_area_rem - 16'(total);
      end
      m_sub_rem = len;
      m_phase = PH_SUBTYPE;
      return NO_RESULT;
   endfunction

   function automatic int sub_finish();
      if (m_area_short) return ST_AREA_OVR;
      if (m_kind == SUB_TIME) begin
         if (m_found[2]) return ST_TIME_UNH;
         m_time = m_shift[31:0];
         m_found[0] = 1'b1;
      end else if (m_kind == SUB_KEY) begin
         m_key = m_shift;
         m_found[1] = 1'b1;
      end
      return area_next();
   endfunction

   function automatic int parse_byte(logic [7:0] b);
      case (m_phase)
         PH_CTB: begin
            if (!b[7]) return ST_BAD_CTB;
            if (b[6]) begin
               m_kind = {2'b00, b[5:0]};
               m_phase = PH_NEWLEN;
            end else begin
               m_kind = {4'b0000, b[5:2]};
               if (b[1:0] == 2'b11) return ST_PARTIAL;
               m_len_left = 3'(1 << b[1:0]);
               m_pkt_rem = '0;
               m_phase = PH_HDRLEN;
            end
            return NO_RESULT;
         end
         PH_NEWLEN: begin
            if (b < 192) begin
               m_pkt_rem = 32'(b);
               return header_check();
            end
            if (b < 224) begin
               m_pkt_rem = 32'(b - 8'd192) << 8;
               m_phase = PH_NEWLEN2;
               return NO_RESULT;
            end
            if (b == 8'd255) begin
               m_len_left = 3'd4;
               m_pkt_rem = '0;
               m_phase = PH_HDRLEN;
               return NO_RESULT;
            end
            return ST_PARTIAL;
         end
         PH_NEWLEN2: begin
            m_pkt_rem = m_pkt_rem + 32'(b) + 32'd192;
            return header_check();
         end
         PH_HDRLEN: begin
            m_pkt_rem = (m_pkt_rem << 8) | 32'(b);
            if (m_len_left > 0) m_len_left = m_len_left - 3'd1;
            return (m_len_left == 0) ? header_check() : NO_RESULT;
         end
         PH_VER: begin
            m_version = b;
            if (b == 8'd3) begin
               m_phase = PH_V3LEN;
               return NO_RESULT;
            end
            if (b == 8'd4) begin
               m_fld_left = 4'd3;
               m_phase = PH_V4HDR;
               return NO_RESULT;
            end
            return ST_VERSION;
         end
         PH_V3LEN: begin
            if (b != 8'd5) return ST_V3_LEN;
            m_phase = PH_V3TYPE;
            return NO_RESULT;
         end
         PH_V3TYPE: begin
            if (b[7:4] != 4'd0) return ST_V3_TYPE;
            m_shift = '0;
            m_fld_left = 4'd4;
            m_phase = PH_V3TIME;
            return NO_RESULT;
         end
         PH_V3TIME: begin
            m_shift = (m_shift << 8) | 64'(b);
            m_fld_left = m_fld_left - 4'd1;
            if (m_fld_left == 0) begin
               m_time = m_shift[31:0];
               m_shift = '0;
               m_fld_left = 4'd8;
               m_phase = PH_V3KEY;
            end
            return NO_RESULT;
         end
         PH_V3KEY: begin
            m_shift = (m_shift << 8) | 64'(b);
            m_fld_left = m_fld_left - 4'd1;
            if (m_fld_left == 0) begin
               m_key = m_shift;
               m_phase = PH_REST;
            end
            return NO_RESULT;
         end
         PH_V4HDR: begin
            m_fld_left = m_fld_left - 4'd1;
            if (m_fld_left == 0) begin
               m_fld_left = 4'd2;
               m_area_rem = '0;
               m_phase = PH_AREALEN;
            end
            return NO_RESULT;
         end
         PH_AREALEN: begin
            m_area_rem = (m_area_rem << 8) | 16'(b);
            m_fld_left = m_fld_left - 4'd1;
            if (m_fld_left == 0) return area_next();
            return NO_RESULT;
         end
         PH_SUBLEN: begin
            if (b < 192) return sublen_set(32'(b), 1);
            if (b < 255) begin
               m_sub_rem = 32'(b - 8'd192) << 8;
               m_phase = PH_SUBLEN2;
               return NO_RESULT;
            end
            m_sub_rem = '0;
            m_len_left = 3'd4;
            m_phase = PH_SUBLEN4;
            return NO_RESULT;
         end
         PH_SUBLEN2: return sublen_set(m_sub_rem + 32'(b) + 32'd192, 2);
         PH_SUBLEN4: begin
            m_sub_rem = (m_sub_rem << 8) | 32'(b);
            if (m_len_left > 0) m_len_left = m_len_left - 3'd1;
            return (m_len_left == 0) ? sublen_set(m_sub_rem, 5) : NO_RESULT;
         end
         PH_SUBTYPE: begin
            m_kind = b;
            m_sub_rem = m_sub_rem - 32'd1;
            if (b == SUB_TIME && m_sub_rem != 32'd4) return ST_MISSIZED;
            if (b == SUB_KEY && m_sub_rem != 32'd8) return ST_MISSIZED;
            m_shift = '0;
            if (m_sub_rem == 0) return sub_finish();
            m_phase = PH_SUBDATA;
            return NO_RESULT;
         end
         PH_SUBDATA: begin
            m_shift = (m_shift << 8) | 64'(b);
            m_sub_rem = m_sub_rem - 32'd1;
            if (m_sub_rem == 0) return sub_finish();
            return NO_RESULT;
         end
         PH_AREASKIP: begin
            if (m_area_rem > 0) m_area_rem = m_area_rem - 16'd1;
            return (m_area_rem == 0) ? area_finish() : NO_RESULT;
         end
         default: return NO_RESULT;
      endcase
   endfunction

   function automatic void push_result(logic [3:0] st);
      result_type r;
      r.status   = st;
      r.version  = m_version;
      r.time_val = m_time;
      r.key_val  = m_key;
      r.count    = m_count;
      sig_result_q.push_back(r);
      mirror_clear();
   endfunction

   // one accepted item through the mirror
   function automatic void predict_item(logic [7:0] b, logic eos);
      int st;
      if (eos) begin
         push_result(ST_TRUNC);
         return;
      end
      m_count = m_count + 33'd1;
      if (m_phase >= PH_VER && m_pkt_rem > 0) m_pkt_rem = m_pkt_rem - 32'd1;
      st = parse_byte(b);
      if (st == NO_RESULT && m_phase >= PH_VER && m_pkt_rem == 0)
         st = (m_phase == PH_REST) ? ST_OK : ST_PKT_OVR;
      if (st != NO_RESULT) push_result(4'(st));
   endfunction

   // ---------------------------------------------------------------
   // Packet builders
   // ---------------------------------------------------------------
   function automatic void put_byte(logic [7:0] b);
      stim_entry_type s;
      s.kind = ENT_BYTE; s.data = b; s.eos = 1'b0;
      stim_q.push_back(s);
      byte_total++;
   endfunction

   function automatic void put_eos();
      stim_entry_type s;
      s.kind = ENT_BYTE; s.data = 8'($urandom); s.eos = 1'b1;
      stim_q.push_back(s);
      byte_total++;
   endfunction

   function automatic void put_marker(int k);
      stim_entry_type s;
      s.kind = k; s.data = '0; s.eos = 1'b0;
      stim_q.push_back(s);
   endfunction

   // subpacket: length encoding 0 one byte, 1 two bytes (one byte below 192), 2 five bytes
   function automatic void add_sub(ref logic [7:0] q[$], input logic [7:0] kind,
                                   input int dlen, input int enc);
      int len;
      len = dlen + 1;
      if (enc == 1 && len >= 192) begin
         q.push_back(8'(((len - 192) >> 8) + 192));
         q.push_back(8'(len - 192));
      end else if (enc == 2) begin
         q.push_back(8'd255);
         q.push_back(8'(len >> 24)); q.push_back(8'(len >> 16));
         q.push_back(8'(len >> 8));  q.push_back(8'(len));
      end else begin
         q.push_back(8'(len));
      end
      q.push_back(kind);
      for (int i = 0; i < dlen; i++) q.push_back(8'($urandom));
   endfunction

   function automatic void add_area(ref logic [7:0] body[$], ref logic [7:0] area[$],
                                    input bit bend);
      int n;
      n = area.size();
      if (bend) n = n + $urandom_range(0, 6) - 3;
      body.push_back(8'(n >> 8));
      body.push_back(8'(n));
      foreach (area[i]) body.push_back(area[i]);
   endfunction

   function automatic void random_extra(ref logic [7:0] q[$]);
      logic [7:0] k;
      k = 8'($urandom_range(3, 127));
      if (k == SUB_KEY) k = 8'd20;
      add_sub(q, k, $urandom_range(0, 6), ($urandom_range(0, 9) == 0) ? 2 : 0);
   endfunction

   function automatic void build_v4_body(ref logic [7:0] body[$], input int pad,
                                         input bit mess);
      logic [7:0] hashed[$];
      logic [7:0] unhashed[$];
      int sel;
      sel = mess ? $urandom_range(0, 7) : 99;
      body.push_back(8'd4);
      repeat (3) body.push_back(8'($urandom));
      if ($urandom_range(0, 2) == 0) random_extra(hashed);
      if (sel == 0)      add_sub(unhashed, SUB_TIME, 4, 0);    // time in wrong area
      else if (sel == 1) add_sub(hashed, SUB_TIME, 3, 0);      // missized
      else if (sel == 2) hashed.push_back(8'd0);               // zero length
      else if (sel != 3) add_sub(hashed, SUB_TIME, 4, ($urandom_range(0, 7) == 0) ? 2 : 0);
      if ($urandom_range(0, 3) == 0) random_extra(hashed);
      if (sel == 4)      add_sub(unhashed, SUB_KEY, 7, 0);
      else if (sel != 5) add_sub(unhashed, SUB_KEY, 8, ($urandom_range(0, 7) == 0) ? 2 : 0);
      if ($urandom_range(0, 3) == 0) random_extra(unhashed);
      add_area(body, hashed, sel == 6);
      add_area(body, unhashed, sel == 7);
      repeat (2 + pad) body.push_back(8'($urandom));
   endfunction

   function automatic void build_v3_body(ref logic [7:0] body[$], input bit mess);
      int sel;
      sel = mess ? $urandom_range(0, 2) : 99;
      body.push_back(8'd3);
      body.push_back(sel == 0 ? 8'($urandom_range(6, 255)) : 8'd5);
      body.push_back(sel == 1 ? 8'($urandom_range(16, 255)) : 8'($urandom_range(0, 15)));
      repeat (12) body.push_back(8'($urandom));
      repeat (4 + $urandom_range(0, 3)) body.push_back(8'($urandom));
   endfunction

   // hdr: 0 new 1 byte, 1 new 2 byte, 2 new 5 byte, 3..5 old 1/2/4 byte
   function automatic void send_packet(ref logic [7:0] body[$], input int hdr,
                                       input int lendelta, input bit cut);
      int n;
      int stop;
      n = body.size() + lendelta;
      if (hdr == 1 && n < 192) hdr = 0;
      if (hdr == 0 && n >= 192) hdr = 2;
      case (hdr)
         0: begin put_byte(8'hC2); put_byte(8'(n)); end
         1: begin
            put_byte(8'hC2);
            put_byte(8'(((n - 192) >> 8) + 192));
            put_byte(8'(n - 192));
         end
         2: begin
            put_byte(8'hC2); put_byte(8'd255);
            put_byte(8'(n >> 24)); put_byte(8'(n >> 16));
            put_byte(8'(n >> 8));  put_byte(8'(n));
         end
         3: begin put_byte(8'h88); put_byte(8'(n)); end
         4: begin put_byte(8'h89); put_byte(8'(n >> 8)); put_byte(8'(n)); end
         default: begin
            put_byte(8'h8A);
            put_byte(8'(n >> 24)); put_byte(8'(n >> 16));
            put_byte(8'(n >> 8));  put_byte(8'(n));
         end
      endcase
      stop = cut ? $urandom_range(0, body.size() - 1) : body.size();
      for (int i = 0; i < stop; i++) put_byte(body[i]);
      if (cut) put_eos();
   endfunction

   function automatic void random_packet(int pad_pct);
      logic [7:0] body[$];
      int r;
      int pad;
      int delta;
      bit mess;
      r = $urandom_range(0, 99);
      mess = ($urandom_range(0, 99) < 25);
      pad = ($urandom_range(0, 99) < pad_pct) ? $urandom_range(170, 260) : $urandom_range(0, 4);
      delta = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, 6)) - 3 : 0;
      if (r < 70) build_v4_body(body, pad, mess);
      else build_v3_body(body, mess);
      send_packet(body, $urandom_range(0, 5), delta, $urandom_range(0, 29) == 0);
      // occasional random byte flip after the fact
      if ($urandom_range(0, 19) == 0) begin
         stim_q[stim_q.size() - 1 - $urandom_range(0, 4)].data = 8'($urandom);
      end
   endfunction

   // ---------------------------------------------------------------
   // Clock, reset, stimulus
   // ---------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      logic [7:0] body[$];
      reset = 1'b1;
      err_count = 0;
      byte_total = 0;
      mirror_clear();

      // directed: header errors first
      put_eos();                                 // stream end with nothing pending
      put_byte(8'h00);                           // bad ctb, all zero
      put_byte(8'h7F);                           // bad ctb, top bit clear
      put_byte(8'h8B);                           // old-format indeterminate length
      put_byte(8'hC2); put_byte(8'hE0);          // new-format partial length
      put_byte(8'hC2); put_byte(8'hFE);
      put_byte(8'hFF); put_byte(8'h30);          // new format, wrong tag
      put_byte(8'h94); put_byte(8'h02);          // old format, wrong tag, checked first
      put_byte(8'hC2); put_byte(8'd18);          // body too short
      put_byte(8'hC2); put_byte(8'd20); put_byte(8'hFF);              // bad version
      put_byte(8'hC2); put_byte(8'd20); put_byte(8'd3); put_byte(8'd4); // v3 length
      put_byte(8'hC2); put_byte(8'd20); put_byte(8'd3); put_byte(8'd5);
      put_byte(8'hF0);                                                 // v3 type
      // directed packets across header forms, well-formed but for a short length field and a cut stream
      body.delete(); build_v3_body(body, 1'b0); send_packet(body, 5, 0, 1'b0);
      body.delete(); build_v4_body(body, 0, 1'b0); send_packet(body, 0, 0, 1'b0);
      body.delete(); build_v4_body(body, 200, 1'b0); send_packet(body, 1, 0, 1'b0);
      body.delete(); build_v4_body(body, 0, 1'b0); send_packet(body, 4, -2, 1'b0);
      body.delete(); build_v4_body(body, 0, 1'b0); send_packet(body, 2, 0, 1'b1);

      // random part, with one long receiver hold-off and one drain pause
      while (byte_total < 680) begin
         if (byte_total > 450 && hold_ticket_marked == 0) begin
            put_marker(ENT_HOLD);
            hold_ticket_marked = 1;
         end
         if (byte_total > 560 && drain_marked == 0) begin
            put_marker(ENT_DRAIN);
            drain_marked = 1;
         end
         case ($urandom_range(0, 9))
            0: repeat ($urandom_range(1, 4)) put_byte(8'($urandom));   // line noise
            1: if ($urandom_range(0, 1) == 0) put_eos(); else random_packet(2);
            default: random_packet(2);
         endcase
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      forever begin
         @(posedge clock);
         if (stim_q.size() == 0 && !req_valid && sig_result_q.size() == 0) break;
      end
      repeat (20) @(posedge clock);
      if (err_count == 0 && sig_result_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // no idling during a window early in the run
   function automatic bit roll_idle();
      if (cyc >= 150 && cyc < 450) return 1'b0;
      return ($urandom_range(0, 99) < 25);
   endfunction

   // ---------------------------------------------------------------
   // Driver: feeds one item per handshake from the pending queue
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid      <= 1'b0;
         req_data_byte  <= '0;
         req_stream_end <= 1'b0;
         hold_ticket    <= 0;
         cyc            <= 0;
      end else begin
         cyc <= cyc + 1;
         if (req_valid && !req_stall) predict_item(req_data_byte, req_stream_end);
         // a stalled item stays put; otherwise choose what to offer next
         if (!(req_valid && req_stall)) begin
            if (stim_q.size() == 0) begin
               req_valid <= 1'b0;
            end else if (stim_q[0].kind == ENT_HOLD) begin
               void'(stim_q.pop_front());
               hold_ticket <= hold_ticket + 1;
               req_valid <= 1'b0;
            end else if (stim_q[0].kind == ENT_DRAIN) begin
               // results of items accepted this edge are already queued
               if (sig_result_q.size() == 0) void'(stim_q.pop_front());
               req_valid <= 1'b0;
            end else if (hold_left == 0 && roll_idle()) begin
               req_valid <= 1'b0;
            end else begin
               req_valid      <= 1'b1;
               req_data_byte  <= stim_q[0].data;
               req_stream_end <= stim_q[0].eos;
               void'(stim_q.pop_front());
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: checks each accepted result against the oldest expected
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_seen <= 0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (sig_result_q.size() == 0) begin
               err_count <= err_count + 1;
               if (err_count < 10)
                  $display("unexpected result: status %0d count %0d", rsp_status,
                           rsp_byte_count);
            end else begin
               if (rsp_status !== sig_result_q[0].status ||
                   rsp_sig_version !== sig_result_q[0].version ||
                   rsp_creation_time !== sig_result_q[0].time_val ||
                   rsp_key_id !== sig_result_q[0].key_val ||
                   rsp_byte_count !== sig_result_q[0].count) begin
                  err_count <= err_count + 1;
                  if (err_count < 10)
                     $display({"mismatch: exp st %0d ver %0d tm %h key %h cnt %0d",
                               " / got st %0d ver %0d tm %h key %h cnt %0d"},
                              sig_result_q[0].status, sig_result_q[0].version,
                              sig_result_q[0].time_val, sig_result_q[0].key_val,
                              sig_result_q[0].count, rsp_status, rsp_sig_version,
                              rsp_creation_time, rsp_key_id, rsp_byte_count);
               end
               void'(sig_result_q.pop_front());
            end
         end
         // long hold-off on request, so the block fills and stalls its input
         if (hold_seen != hold_ticket) begin
            hold_seen <= hold_ticket;
            hold_left <= 400;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= (hold_left > 1);
         end else begin
            rsp_stall <= roll_idle();
         end
      end
   end

endmodule
